// ===== hdl/assert_macros.svh =====
// Assertion macros used by the alarm priority aggregator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define APA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define APA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/apa_pkg.sv =====
// Shared types, codes and constants of the alarm priority aggregator.
// No dependencies; imported by every module of the block.
`default_nettype none

package apa_pkg;

    // Sizing
    localparam int NUM_ACTIONS   = 16;
    localparam int COUNT_WIDTH   = 16;
    localparam int NUM_SYS_TYPES = 5;
    localparam int AIU_W         = 5;
    localparam int NA_W          = $clog2(NUM_ACTIONS + 1);
    localparam int LIM_W         = (NA_W > AIU_W) ? NA_W : AIU_W;
    localparam logic [LIM_W-1:0]       NUM_ACTIONS_L = LIM_W'(NUM_ACTIONS);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX       = '1;

    // Port widths
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;

    // Command codes
    typedef enum logic [1:0] {
        CMD_TRIGGER = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_EVAL    = 2'd2
    } cmd_t;

    // Event type codes
    typedef enum logic [2:0] {
        EVT_ALARM       = 3'd0,
        EVT_WARNING     = 3'd1,
        EVT_SOFT_WARN   = 3'd2,
        EVT_MAINTENANCE = 3'd3,
        EVT_OKAY        = 3'd4,
        EVT_CUSTOM      = 3'd5
    } evt_t;

    // Controller state; ST_NONE means nothing was published since reset
    typedef enum logic [2:0] {
        ST_OKAY    = 3'd0,
        ST_WARNING = 3'd1,
        ST_ALARM   = 3'd2,
        ST_MAINT   = 3'd3,
        ST_NONE    = 3'd4
    } ctrl_state_t;

    // Action request codes
    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_INVOKE = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE           = 2'd0,
        ERR_INVALID_ACTION = 2'd1,
        ERR_UNDERFLOW      = 2'd2
    } err_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_ACTION       = 3'd0,
        CFG_WARNING_ACTION     = 3'd1,
        CFG_MAINTENANCE_ACTION = 3'd2,
        CFG_OKAY_ACTION        = 3'd3,
        CFG_ACTIONS_IN_USE     = 3'd4,
        CFG_STATUS_REGISTER    = 3'd5
    } cfg_idx_t;

    // Configuration register file contents
    typedef struct packed {
        logic [3:0]       alarm_action;
        logic [3:0]       warning_action;
        logic [3:0]       maintenance_action;
        logic [3:0]       okay_action;
        logic [AIU_W-1:0] actions_in_use;
        logic [15:0]      status_register;
    } cfg_t;

    // Input word, last field in the lowest bits
    typedef struct packed {
        logic [3:0] custom_action;
        logic [2:0] event_type;
        logic [1:0] command;
    } in_item_t;

    localparam int IN_ITEM_W = $bits(in_item_t);

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  error_code;
        logic [15:0] status_address;
        logic [1:0]  controller_state;
        logic        publish;
        logic [3:0]  action_index;
        logic [1:0]  action_request;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

// ===== hdl/alarm_priority_aggregator.sv =====
// Top level of the alarm priority aggregator: stream ports, input and output registers.
// Depends on apa_pkg, apa_cfg_regs and apa_core.
`default_nettype none

// Takes one event word per cycle while s_axis_tready is high and returns exactly one
// result word per event. The word is held in an input register, the counter update
// and priority choice run in combinational logic, and the result lands in the output
// register, from which m_axis_tvalid is driven. Throughput is one word per clock while
// the output side takes words; s_axis_tready falls only when both registers hold words
// and m_axis_tready is low. Configuration writes are taken at any time but must be made
// while no events are in flight.

module alarm_priority_aggregator
    import apa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // slave side: [1:0] command, [4:2] event_type, [8:5] custom_action, rest zero
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_W-1:0]      s_axis_tdata,
    // master side: [1:0] action_request, [5:2] action_index, [6] publish,
    // [8:7] controller_state, [24:9] status_address, [26:25] error_code, rest zero
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [OUT_W-1:0]          m_axis_tdata,
    // configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic     in_valid_reg;
    in_item_t in_data_reg;
    logic     out_valid_reg;
    res_t     out_data_reg;
    logic     out_free;
    logic     step;
    cfg_t     cfg;
    res_t     res;

    // Handshake: the input register drains whenever the output register can load
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    apa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    apa_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_data_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_data_reg <= in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - RES_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

// ===== hdl/apa_cfg_regs.sv =====
// Configuration register file of the alarm priority aggregator.
// Depends on apa_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module apa_cfg_regs
    import apa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ALARM_ACTION:       cfg_next.alarm_action       = cfg_data[3:0];
                CFG_WARNING_ACTION:     cfg_next.warning_action     = cfg_data[3:0];
                CFG_MAINTENANCE_ACTION: cfg_next.maintenance_action = cfg_data[3:0];
                CFG_OKAY_ACTION:        cfg_next.okay_action        = cfg_data[3:0];
                CFG_ACTIONS_IN_USE:     cfg_next.actions_in_use     = cfg_data[AIU_W-1:0];
                CFG_STATUS_REGISTER:    cfg_next.status_register    = cfg_data[15:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_action       <= 4'd0;
            cfg_reg.warning_action     <= 4'd1;
            cfg_reg.maintenance_action <= 4'd3;
            cfg_reg.okay_action        <= 4'd4;
            cfg_reg.actions_in_use     <= AIU_W'(NUM_ACTIONS);
            cfg_reg.status_register    <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/apa_core.sv =====
// Event counters, controller state and result logic of the aggregator.
// Depends on apa_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module apa_core
    import apa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output res_t      res
);

    logic [COUNT_WIDTH-1:0] counts_reg  [NUM_SYS_TYPES];
    logic [COUNT_WIDTH-1:0] counts_next [NUM_SYS_TYPES];
    ctrl_state_t            state_reg;
    ctrl_state_t            state_next;

    logic [COUNT_WIDTH-1:0] cnt_sel;
    logic [COUNT_WIDTH-1:0] cnt_upd;
    logic                   cnt_wr;
    logic                   do_eval;
    logic                   is_sys;
    logic [LIM_W-1:0]       aiu_ext;
    logic [LIM_W-1:0]       limit;
    logic [NUM_SYS_TYPES-1:0] latch;
    ctrl_state_t            eval_state;
    logic [3:0]             eval_act;

    // Custom action limit: smaller of actions in use and the table size
    always_comb
    begin
        aiu_ext = LIM_W'(cfg.actions_in_use);
        limit   = (aiu_ext > NUM_ACTIONS_L) ? NUM_ACTIONS_L : aiu_ext;
    end

    // Event handling, count update and state evaluation
    always_comb
    begin
        cnt_sel = '0;
        for (int i = 0; i < NUM_SYS_TYPES; i++)
        begin
            if (item.event_type == 3'(i))
                cnt_sel = counts_reg[i];
        end
        is_sys  = (item.event_type < EVT_CUSTOM);
        res     = '0;
        cnt_upd = cnt_sel;
        cnt_wr  = 1'b0;
        do_eval = 1'b0;

        case (item.command)
            CMD_TRIGGER, CMD_CLEAR:
            begin
                if (item.event_type == EVT_CUSTOM)
                begin
                    if (LIM_W'(item.custom_action) < limit)
                    begin
                        res.action_request = (item.command == CMD_TRIGGER) ?
                                             REQ_INVOKE : REQ_CLEAR;
                        res.action_index   = item.custom_action;
                    end
                    else
                    begin
                        res.error_code = ERR_INVALID_ACTION;
                    end
                end
                else if (is_sys)
                begin
                    if (item.command == CMD_TRIGGER)
                    begin
                        // saturating increment, latch set, always evaluate
                        cnt_upd = (cnt_sel == CNT_MAX) ? cnt_sel : cnt_sel + 1'b1;
                        cnt_wr  = 1'b1;
                        do_eval = 1'b1;
                    end
                    else if (cnt_sel == '0)
                    begin
                        res.error_code = ERR_UNDERFLOW;
                    end
                    else
                    begin
                        // evaluate only when the latch drops
                        cnt_upd = cnt_sel - 1'b1;
                        cnt_wr  = 1'b1;
                        do_eval = (cnt_sel == COUNT_WIDTH'(1));
                    end
                end
            end
            CMD_EVAL:
                do_eval = 1'b1;
            default:
                ;
        endcase

        for (int i = 0; i < NUM_SYS_TYPES; i++)
        begin
            counts_next[i] = (cnt_wr && item.event_type == 3'(i)) ? cnt_upd : counts_reg[i];
            latch[i]       = |counts_next[i];
        end

        // Priority: maintenance, alarm, warning, okay
        if (latch[EVT_MAINTENANCE])
        begin
            eval_state = ST_MAINT;
            eval_act   = cfg.maintenance_action;
        end
        else if (latch[EVT_ALARM])
        begin
            eval_state = ST_ALARM;
            eval_act   = cfg.alarm_action;
        end
        else if (latch[EVT_WARNING])
        begin
            eval_state = ST_WARNING;
            eval_act   = cfg.warning_action;
        end
        else
        begin
            eval_state = ST_OKAY;
            eval_act   = cfg.okay_action;
        end

        state_next = state_reg;
        if (do_eval)
        begin
            res.publish          = 1'b1;
            res.controller_state = eval_state[1:0];
            res.status_address   = cfg.status_register;
            if (eval_state != state_reg)
            begin
                res.action_request = REQ_INVOKE;
                res.action_index   = eval_act;
                state_next         = eval_state;
            end
        end
    end

    // State registers advance only when the word moves to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SYS_TYPES; i++)
                counts_reg[i] <= '0;
            state_reg <= ST_NONE;
        end
        else if (step)
        begin
            counts_reg <= counts_next;
            state_reg  <= state_next;
        end
    end

    // Published state becomes the held state
    `APA_ASSERT_NXT(a_state_follows_publish, clk, rst_n, step && res.publish,
        state_reg[1:0] == $past(res.controller_state) && !state_reg[2],
        "held state differs from the published state")

    // An error word neither requests nor publishes
    `APA_ASSERT_IMP(a_error_quiet, clk, rst_n, step && res.error_code != ERR_NONE,
        res.action_request == REQ_NONE && !res.publish,
        "error word carries a request or a publish")

    // A published invoke only comes with a state change
    `APA_ASSERT_IMP(a_invoke_on_change, clk, rst_n,
        step && res.publish && res.action_request == REQ_INVOKE,
        state_next != state_reg,
        "state entry action without a state change")

endmodule

`default_nettype wire
